[design/kce_pkg.sv]
// kce_pkg: shared widths, codes and structs for the k-combination enumerator.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package kce_pkg;

    localparam int POS_W      = 8;   // stored position / set size width
    localparam int SIZE_W     = 8;   // set_size register width
    localparam int CHOOSE_W   = 5;   // choose_count register width
    localparam int SLOT_W     = 4;   // slot field width
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam int Q_DEPTH    = 2;   // request queue entries

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SET_SIZE     = 1'b0,
        REG_CHOOSE_COUNT = 1'b1
    } cfg_addr_t;

    // Request class decided at the front
    typedef enum logic [1:0] {
        OP_RESTART = 2'd0,
        OP_NEXT    = 2'd1,
        OP_BADCFG  = 2'd2
    } op_t;

    typedef struct packed {
        logic [SIZE_W-1:0]   set_size;
        logic [CHOOSE_W-1:0] choose_count;
    } cfg_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } push_t;

    typedef struct packed {
        logic [POS_W-1:0]  item_index;
        logic [SLOT_W-1:0] slot;
        logic              last;
        logic              valid_res;
    } res_t;

endpackage

`default_nettype wire

[design/kce_ifs.sv]
// Channel interfaces: request, result and configuration write words.
// Depends on kce_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface kce_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface kce_res_if;
    logic                           valid;
    logic                           ready;
    logic [kce_pkg::POS_W-1:0]      item_index;
    logic [kce_pkg::SLOT_W-1:0]     slot;
    logic                           last;
    logic                           valid_res;

    modport source (output valid, output item_index, output slot, output last,
                    output valid_res, input ready);
    modport sink   (input valid, input item_index, input slot, input last,
                    input valid_res, output ready);
endinterface

interface kce_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [kce_pkg::CFG_ADDR_W-1:0]  addr;
    logic [kce_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

[design/kce_front.sv]
// kce_front: configuration registers and request classification.
// Depends on kce_pkg; pushes classified words into kce_queue.
`timescale 1ns / 1ps
`default_nettype none

module kce_front #(
    parameter int MAX_K = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire logic                            req_restart,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [kce_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [kce_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            q_full,
    output kce_pkg::push_t                       push,
    output kce_pkg::cfg_t                        cfg_out
);

    logic [kce_pkg::SIZE_W-1:0]   set_size_reg;
    logic [kce_pkg::CHOOSE_W-1:0] choose_count_reg;
    logic                         bad_cfg;

    assign cfg_ready = 1'b1;
    assign req_ready = !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg     <= kce_pkg::SIZE_W'(1);
            choose_count_reg <= kce_pkg::CHOOSE_W'(1);
        end
        else if (cfg_valid)
        begin
            case (kce_pkg::cfg_addr_t'(cfg_addr))
                kce_pkg::REG_SET_SIZE:
                    set_size_reg <= cfg_data[kce_pkg::SIZE_W-1:0];
                kce_pkg::REG_CHOOSE_COUNT:
                    choose_count_reg <= cfg_data[kce_pkg::CHOOSE_W-1:0];
                default: ;
            endcase
        end
    end

    // k of zero, above the lane count, or above n cannot give a combination
    assign bad_cfg = (choose_count_reg == '0)
                  || (int'(choose_count_reg) > MAX_K)
                  || (kce_pkg::SIZE_W'(choose_count_reg) > set_size_reg);

    always_comb
    begin
        push.valid = req_valid && !q_full;
        if (req_restart)
            push.op = kce_pkg::OP_RESTART;
        else if (bad_cfg)
            push.op = kce_pkg::OP_BADCFG;
        else
            push.op = kce_pkg::OP_NEXT;
    end

    assign cfg_out.set_size     = set_size_reg;
    assign cfg_out.choose_count = choose_count_reg;

endmodule

`default_nettype wire

[design/kce_queue.sv]
// kce_queue: two-entry FIFO of classified requests between front and back.
// Depends on kce_pkg for op_t and push_t.
`timescale 1ns / 1ps
`default_nettype none

module kce_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire kce_pkg::push_t push,
    output logic                full,
    input  wire logic           pop,
    output logic                empty,
    output kce_pkg::op_t        head
);

    localparam int PTR_W = $clog2(kce_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(kce_pkg::Q_DEPTH + 1);

    kce_pkg::op_t     entry_reg [kce_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(kce_pkg::Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push.op;
    end

endmodule

`default_nettype wire

[design/kce_back.sv]
// kce_back: position store, scan/refill sequencer and output register.
// Depends on kce_pkg; pops requests from kce_queue.
`timescale 1ns / 1ps
`default_nettype none

module kce_back #(
    parameter int MAX_K      = 16,
    parameter int INDEX_BITS = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire kce_pkg::cfg_t  cfg,
    input  wire logic           q_empty,
    input  wire kce_pkg::op_t   q_head,
    output logic                q_pop,
    output logic                res_valid,
    input  wire logic           res_ready,
    output kce_pkg::res_t       res
);

    localparam int POS_W = kce_pkg::POS_W;
    localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CNT_W = $clog2(MAX_K + 1);
    localparam int LIM_W = POS_W + CNT_W + 1;
    localparam logic [POS_W-1:0] IDX_MASK =
        (INDEX_BITS >= POS_W) ? {POS_W{1'b1}} : POS_W'((1 << INDEX_BITS) - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_FILL  = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_INVAL = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [POS_W-1:0]  val_reg, val_next;
    logic              first_reg, first_next;
    logic              exh_reg, exh_next;
    logic [POS_W-1:0]  pos_reg [MAX_K];
    logic [MAX_K-1:0]  pos_vld_reg;
    logic              out_valid_reg, out_valid_next;
    kce_pkg::res_t     out_reg;

    logic [IDX_W-1:0]  idx;
    logic [POS_W-1:0]  rd_data;
    logic [LIM_W-1:0]  limit;
    logic [CNT_W-1:0]  last_idx;
    logic              at_last;
    logic              wr_en;
    logic [POS_W-1:0]  wr_val;
    logic              out_free;
    logic              load;
    kce_pkg::res_t     load_res;

    assign idx      = cnt_reg[IDX_W-1:0];
    assign rd_data  = pos_vld_reg[idx] ? pos_reg[idx] : '0;
    assign limit    = LIM_W'(cfg.set_size) - LIM_W'(cfg.choose_count) + LIM_W'(cnt_reg);
    assign last_idx = CNT_W'(cfg.choose_count) - CNT_W'(1);
    assign at_last  = (cnt_reg == last_idx);
    assign out_free = !out_valid_reg || res_ready;

    always_comb
    begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        val_next           = val_reg;
        first_next         = first_reg;
        exh_next           = exh_reg;
        q_pop              = 1'b0;
        wr_en              = 1'b0;
        wr_val             = val_reg;
        load               = 1'b0;
        load_res.item_index = '0;
        load_res.slot       = '0;
        load_res.last       = 1'b1;
        load_res.valid_res  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    case (q_head)
                        kce_pkg::OP_RESTART:
                        begin
                            first_next = 1'b1;
                            exh_next   = 1'b0;
                        end
                        kce_pkg::OP_BADCFG:
                        begin
                            exh_next   = 1'b1;
                            state_next = ST_INVAL;
                        end
                        kce_pkg::OP_NEXT:
                        begin
                            if (exh_reg)
                                state_next = ST_INVAL;
                            else if (first_reg)
                            begin
                                first_next = 1'b0;
                                cnt_next   = '0;
                                val_next   = '0;
                                state_next = ST_FILL;
                            end
                            else
                            begin
                                cnt_next   = last_idx;
                                state_next = ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // walk right to left for a position still below its limit
            ST_SCAN:
            begin
                if (LIM_W'(rd_data) < limit)
                begin
                    wr_en  = 1'b1;
                    wr_val = rd_data + POS_W'(1);
                    if (at_last)
                    begin
                        cnt_next   = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + CNT_W'(1);
                        val_next   = rd_data + POS_W'(2);
                        state_next = ST_FILL;
                    end
                end
                else if (cnt_reg == '0)
                begin
                    exh_next   = 1'b1;
                    state_next = ST_INVAL;
                end
                else
                    cnt_next = cnt_reg - CNT_W'(1);
            end
            ST_FILL:
            begin
                wr_en    = 1'b1;
                val_next = val_reg + POS_W'(1);
                if (at_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load                = 1'b1;
                    load_res.item_index = rd_data & IDX_MASK;
                    load_res.slot       = kce_pkg::SLOT_W'(cnt_reg);
                    load_res.last       = at_last;
                    load_res.valid_res  = 1'b1;
                    if (at_last)
                        state_next = ST_IDLE;
                    else
                        cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_INVAL:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (res_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            first_reg     <= 1'b1;
            exh_reg       <= 1'b0;
            pos_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            first_reg     <= first_next;
            exh_reg       <= exh_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
                pos_vld_reg[idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        if (wr_en)
            pos_reg[idx] <= wr_val;
        if (load)
            out_reg <= load_res;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

`default_nettype wire

[design/k_combination_enumerator.sv]
// k_combination_enumerator: top level joining front, queue and back.
// Depends on kce_pkg, kce_ifs, kce_front, kce_queue and kce_back.
//
//  channel | dir | word contents                          | transfer
//  --------+-----+----------------------------------------+------------------
//  req     | in  | restart                                | valid & ready
//  res     | out | item_index, slot, last, valid_res      | valid & ready
//  cfg     | in  | addr (0 set_size, 1 choose_count), data| valid & ready
//
// Restart words give no result word; they only rearm the back end.
// A next request fills the positions and then emits them for the first combination,
// and later scans right to left for the position i that moves, refills the positions
// after i and emits; the single back-end sequencer handles one position per cycle
// while the output is not stalled. Requests already exhausted or with a bad config
// give one invalid word, as does a scan that finds no position to move.
// Reset clears control, config (n = k = 1) and the position valid bits at once.
// The queue takes requests while the back end works; the output register
// holds a word while res is stalled.
`timescale 1ns / 1ps
`default_nettype none

module k_combination_enumerator #(
    parameter int MAX_K      = 16,
    parameter int INDEX_BITS = 8
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    kce_req_if.sink     req,
    kce_res_if.source   res,
    kce_cfg_if.sink     cfg
);

    kce_pkg::push_t  push;
    kce_pkg::cfg_t   cfg_regs;
    kce_pkg::op_t    q_head;
    kce_pkg::res_t   res_word;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    logic            res_valid;

    // Front: config registers, request classification
    kce_front #(
        .MAX_K (MAX_K)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_ready   (req.ready),
        .req_restart (req.restart),
        .cfg_valid   (cfg.valid),
        .cfg_ready   (cfg.ready),
        .cfg_addr    (cfg.addr),
        .cfg_data    (cfg.data),
        .q_full      (q_full),
        .push        (push),
        .cfg_out     (cfg_regs)
    );

    // Decoupling queue
    kce_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .head  (q_head)
    );

    // Back: scan, refill, emit
    kce_back #(
        .MAX_K      (MAX_K),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_regs),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (res.ready),
        .res       (res_word)
    );

    assign res.valid      = res_valid;
    assign res.item_index = res_word.item_index;
    assign res.slot       = res_word.slot;
    assign res.last       = res_word.last;
    assign res.valid_res  = res_word.valid_res;

endmodule

`default_nettype wire

[design/kce_checker.sv]
// kce_checker: port-level assertions on the result channel, bound to the top.
// Depends on kce_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module kce_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        res_valid,
    input wire logic                        res_ready,
    input wire logic [kce_pkg::POS_W-1:0]   res_item_index,
    input wire logic [kce_pkg::SLOT_W-1:0]  res_slot,
    input wire logic                        res_last,
    input wire logic                        res_valid_res
);

    // stalled word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid
            && $stable({res_item_index, res_slot, res_last, res_valid_res}))
        else $error("result word changed while stalled");

    // exhausted word is a single fixed word
    a_invalid_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_valid_res |-> res_last && res_slot == '0
            && res_item_index == '0)
        else $error("malformed invalid result");

    // a combination streams without gaps, slot counting up
    a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last |=> res_valid && res_valid_res
            && res_slot == $past(res_slot) + kce_pkg::SLOT_W'(1))
        else $error("combination word missing or out of order");

endmodule

bind k_combination_enumerator kce_checker u_kce_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_item_index (res.item_index),
    .res_slot       (res.slot),
    .res_last       (res.last),
    .res_valid_res  (res.valid_res)
);

`default_nettype wire

[tb/sv/tb_top.sv]
// tb_top: self-checking bench for k_combination_enumerator. Predicts each result word
// from its own copy of n, k and the stored positions. Checks them in order.
// Depends on kce_pkg, kce_ifs and the design files; needs no other input.
`timescale 1ns / 1ps

module tb_top;

    import kce_pkg::*;

    localparam int MAX_CHOOSE    = 16;   // MAX_K of the instance
    localparam int INDEX_W       = 8;    // INDEX_BITS of the instance
    localparam int ITEMS_TARGET  = 300;  // request words before the random part stops
    localparam int SETTLE_CYCLES = 40;   // trailing restarts may still be in flight
    localparam int DRAIN_CYCLES  = 60;   // quiet time at the end
    localparam int STALL_LIMIT   = 2000; // cycles without any transfer before giving up
    localparam int SHOW_LIMIT    = 10;   // mismatches printed in full

    logic clk;
    logic rst_n;

    kce_req_if req_if ();
    kce_res_if res_if ();
    kce_cfg_if cfg_if ();

    k_combination_enumerator #(
        .MAX_K      (MAX_CHOOSE),
        .INDEX_BITS (INDEX_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    // ------------------------------------------------------------------
    // Predictor state: shadow registers and the enumerator's own state
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0]   shadow_n;
    logic [CHOOSE_W-1:0] shadow_k;
    logic [POS_W-1:0]    combo_pos [MAX_CHOOSE];
    bit                  first_pending;
    bit                  exhausted;

    res_t expected_words [$];     // result words still owed by the block
    res_t want_word;
    res_t got_word;

    int  fail_count;
    int  mismatch_count;
    int  items_sent;
    int  quiet_cycles;
    bit  no_gaps;                 // set for a stretch with no idling on either side

    // Clock, period 4 ns
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void owe_invalid();
        res_t w;
        w.item_index = '0;
        w.slot       = '0;
        w.last       = 1'b1;
        w.valid_res  = 1'b0;
        expected_words.push_back(w);
    endfunction

    // one word per position, last flag on the final one
    function automatic void owe_combination(input int k);
        res_t w;
        for (int j = 0; j < k; j++)
        begin
            w.item_index = combo_pos[j] & POS_W'((1 << INDEX_W) - 1);
            w.slot       = SLOT_W'(j);
            w.last       = (j == k - 1);
            w.valid_res  = 1'b1;
            expected_words.push_back(w);
        end
    endfunction

    // Advance the shadow enumerator by one accepted request word.
    function automatic void advance_enumerator(input bit restart);
        int n;
        int k;
        n = int'(shadow_n);
        k = int'(shadow_k);
        if (restart)
        begin
            // restart only rearms; no result word
            first_pending = 1'b1;
            exhausted     = 1'b0;
            return;
        end
        if (exhausted)
        begin
            owe_invalid();
            return;
        end
        // k zero, k beyond the position store, or k above n: sticky invalid
        if (k == 0 || k > MAX_CHOOSE || k > n)
        begin
            exhausted = 1'b1;
            owe_invalid();
            return;
        end
        if (first_pending)
        begin
            first_pending = 1'b0;
            for (int j = 0; j < k; j++)
                combo_pos[j] = POS_W'(j);
            owe_combination(k);
            return;
        end
        // rightmost position still below its limit moves up, the rest refill.
        // Stale positions left by an earlier, larger k are used as they stand, as in the block.
        for (int i = k - 1; i >= 0; i--)
        begin
            if (int'(combo_pos[i]) < n - k + i)
            begin
                combo_pos[i] = combo_pos[i] + 1'b1;
                for (int j = i + 1; j < k; j++)
                    combo_pos[j] = combo_pos[j-1] + 1'b1;
                owe_combination(k);
                return;
            end
        end
        exhausted = 1'b1;
        owe_invalid();
    endfunction

    // ------------------------------------------------------------------
    // Result side: random backpressure on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (no_gaps)
            res_if.ready = 1'b1;
        else
            res_if.ready = ($urandom_range(99) >= 10);
    end

    function automatic void log_bad_word(input string why, input res_t want, input res_t got);
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
            $display({"[%0t] %s: expected idx=%0d slot=%0d last=%0b valid_res=%0b,",
                      " got idx=%0d slot=%0d last=%0b valid_res=%0b"},
                     $time, why, want.item_index, want.slot, want.last, want.valid_res,
                     got.item_index, got.slot, got.last, got.valid_res);
    endfunction

    // Compare each accepted result word with the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got_word.item_index = res_if.item_index;
            got_word.slot       = res_if.slot;
            got_word.last       = res_if.last;
            got_word.valid_res  = res_if.valid_res;
            if (expected_words.size() == 0)
                log_bad_word("unexpected result word", '0, got_word);
            else
            begin
                want_word = expected_words.pop_front();
                if (got_word.item_index !== want_word.item_index ||
                    got_word.slot       !== want_word.slot       ||
                    got_word.last       !== want_word.last       ||
                    got_word.valid_res  !== want_word.valid_res)
                    log_bad_word("result word mismatch", want_word, got_word);
            end
        end
    end

    // Watchdog: any transfer on any channel keeps it quiet
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers; every task starts and ends just after a falling edge
    // ------------------------------------------------------------------

    // Send one request word and predict on acceptance.
    task automatic send_request(input bit restart);
        while (!no_gaps && $urandom_range(99) < 10)
            @(negedge clk);
        req_if.valid   = 1'b1;
        req_if.restart = restart;
        do
            @(posedge clk);
        while (!req_if.ready);
        advance_enumerator(restart);
        items_sent++;
        @(negedge clk);
        req_if.valid   = 1'b0;
        req_if.restart = 1'($urandom_range(1));   // noise while not valid
    endtask

    task automatic wait_results_drained();
        while (expected_words.size() != 0)
            @(negedge clk);
    endtask

    // Register write, only once the block has gone idle
    task automatic write_reg(input cfg_addr_t addr, input logic [CFG_DATA_W-1:0] data);
        wait_results_drained();
        // a trailing restart gives no word, so give the back end time to finish it
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_if.valid = 1'b1;
        cfg_if.addr  = addr;
        cfg_if.data  = data;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        if (addr == REG_SET_SIZE)
            shadow_n = data;
        else
            shadow_k = data[CHOOSE_W-1:0];
        @(negedge clk);
        cfg_if.valid = 1'b0;
        cfg_if.data  = CFG_DATA_W'($urandom);
    endtask

    task automatic send_nexts(input int count);
        repeat (count) send_request(1'b0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values n = k = 1: one single-word combination, exhaustion, then a restart and the combination again
    task automatic test_reset_defaults();
        send_nexts(2);
        send_request(1'b1);
        send_nexts(1);
    endtask

    // Full walk of C(4,2) plus one request past the end
    task automatic test_small_walk();
        write_reg(REG_SET_SIZE, 8'd4);
        write_reg(REG_CHOOSE_COUNT, 8'd2);
        send_request(1'b1);
        send_nexts(7);
    endtask

    // Largest n and k, k of zero, k above the store, n of zero, k equal to n
    task automatic test_extremes();
        write_reg(REG_SET_SIZE, 8'hFF);
        write_reg(REG_CHOOSE_COUNT, 8'd16);
        send_request(1'b1);
        send_nexts(2);
        // upper data bits are dropped by the 5-bit register: k = 0
        write_reg(REG_CHOOSE_COUNT, 8'hE0);
        send_request(1'b1);
        send_nexts(2);
        write_reg(REG_CHOOSE_COUNT, 8'h11);
        send_request(1'b1);
        send_nexts(1);
        write_reg(REG_SET_SIZE, 8'd0);
        write_reg(REG_CHOOSE_COUNT, 8'h21);
        send_request(1'b1);
        send_nexts(1);
        write_reg(REG_SET_SIZE, 8'd3);
        write_reg(REG_CHOOSE_COUNT, 8'd3);
        send_request(1'b1);
        send_nexts(2);
    endtask

    // k = 1 over more than 128 items so every index bit toggles; no idling here
    task automatic test_long_walk();
        int n;
        n = $urandom_range(160, 129);
        no_gaps = 1'b1;
        write_reg(REG_SET_SIZE, SIZE_W'(n));
        write_reg(REG_CHOOSE_COUNT, 8'd1);
        send_request(1'b1);
        send_nexts(n + 1);
        no_gaps = 1'b0;
    endtask

    // Phases of random config followed by mostly well-formed request runs
    task automatic test_random_phases();
        int sel;
        int n;
        int k;
        int count;
        while (items_sent < ITEMS_TARGET)
        begin
            sel = $urandom_range(99);
            if (sel < 70)
            begin
                n = $urandom_range(12, 1);
                k = $urandom_range((n < 6) ? n : 6, 1);
            end
            else if (sel < 78)
            begin
                n = $urandom_range(255, 1);
                k = $urandom_range(3, 1);
            end
            else if (sel < 86)
            begin
                n = $urandom_range(20, 16);
                k = $urandom_range(16, 13);
            end
            else
            begin
                // bad settings: k of zero, k above the store, k above n
                n = $urandom_range(5, 0);
                case ($urandom_range(2))
                    0: k = 0;
                    1: k = $urandom_range(31, 17);
                    default: k = n + $urandom_range(4, 1);
                endcase
            end
            // sometimes keep one register as it stands, mid-sequence
            if ($urandom_range(4) != 0)
                write_reg(REG_SET_SIZE, SIZE_W'(n));
            if ($urandom_range(4) != 0)
                write_reg(REG_CHOOSE_COUNT, {3'($urandom), CHOOSE_W'(k)});
            if ($urandom_range(99) < 85)
                send_request(1'b1);
            count = $urandom_range(24, 4);
            for (int i = 0; i < count; i++)
            begin
                send_request($urandom_range(99) < 6);
                if ($urandom_range(99) < 3)
                    wait_results_drained();   // sender holds off until all words are back
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        fail_count     = 0;
        mismatch_count = 0;
        items_sent     = 0;
        quiet_cycles   = 0;
        no_gaps        = 1'b0;
        shadow_n       = SIZE_W'(1);
        shadow_k       = CHOOSE_W'(1);
        first_pending  = 1'b1;
        exhausted      = 1'b0;
        for (int j = 0; j < MAX_CHOOSE; j++)
            combo_pos[j] = '0;

        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.restart = 1'b0;
        res_if.ready   = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.addr    = REG_SET_SIZE;
        cfg_if.data    = '0;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_small_walk();
        test_extremes();
        test_long_walk();
        test_random_phases();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_words.size() != 0)
            fail_count++;

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
design/kce_pkg.sv
design/kce_ifs.sv
design/kce_front.sv
design/kce_queue.sv
design/kce_back.sv
design/k_combination_enumerator.sv
design/kce_checker.sv
tb/sv/tb_top.sv
